FILE: sv/wpcm_pkg.sv
// shared types, constants and weight table for the wall proximity cost map
package wpcm_pkg;

  localparam int MAP_SIDE_DEF   = 1024;
  localparam int MAX_RADIUS_DEF = 8;

  localparam int COORD_W   = 12;  // signed tile coordinate with window offset
  localparam int WORD_W    = 6;   // word index within a row
  localparam int ROWCNT_W  = 5;   // window row counter
  localparam int RAD_W     = 5;   // effective radius
  localparam int BEST_W    = 10;  // squared distance
  localparam int DATA_W    = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [0:0] {
    CFG_NEAR_RADIUS    = 1'b0,
    CFG_DEFAULT_WEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                clr_step;
    logic                wr_in;
    logic                load_q;
    logic                rd_self;
    logic                chk_self;
    logic                rd_lo;
    logic                rd_hi;
    logic                cap_lo;
    logic                cap_hi;
    logic                out_load;
    logic [ROWCNT_W-1:0] row_idx;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic self_solid;
    logic r_zero;
    logic last_row;
  } sts_t;

  typedef logic [15:0] lut_t [256];

  // round(49152 / sqrt(d)) with halves upward, d of zero taken as one
  function automatic lut_t build_weight_lut();
    lut_t              lut;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   mid;
    longint unsigned   t;
    longint unsigned   dd;
    longint unsigned   k;
    k = 64'd4 * 64'd49152 * 64'd49152;
    for (int d = 0; d < 256; d++) begin
      dd = (d == 0) ? 64'd1 : longint'(d);
      lo = 1;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t   = 2 * mid - 1;
        if (t * t * dd <= k) lo = mid;
        else hi = mid - 1;
      end
      lut[d] = lo[15:0];
    end
    return lut;
  endfunction

  localparam lut_t WEIGHT_LUT = build_weight_lut();

endpackage

FILE: sv/wpcm_ram.sv
// generic simple dual port ram with registered read
module wpcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: sv/wpcm_ctrl.sv
// query sequencer: clearing pass, self check, window row reads, result handoff
module wpcm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_operation,
  output logic            out_valid,
  input  logic            out_ready,
  output wpcm_pkg::cmd_t  cmd,
  input  wpcm_pkg::sts_t  sts
);
  import wpcm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CLEAR    = 9'b000000010,
    S_SELF_RD  = 9'b000000100,
    S_SELF_CHK = 9'b000001000,
    S_ROW_LO   = 9'b000010000,
    S_ROW_HI   = 9'b000100000,
    S_ROW_CMB  = 9'b001000000,
    S_FINISH   = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ROWCNT_W-1:0] row_r, row_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.row_idx   = row_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == OP_QUERY) begin
            cmd.load_q = 1'b1;
            state_nxt  = S_SELF_RD;
          end else begin
            cmd.wr_in = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_SELF_RD: begin
        cmd.rd_self = 1'b1;
        state_nxt   = S_SELF_CHK;
      end
      S_SELF_CHK: begin
        cmd.chk_self = 1'b1;
        row_nxt      = '0;
        if (sts.self_solid || sts.r_zero) state_nxt = S_RESULT;
        else state_nxt = S_ROW_LO;
      end
      S_ROW_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_ROW_HI;
      end
      S_ROW_HI: begin
        cmd.rd_hi  = 1'b1;
        cmd.cap_lo = 1'b1;
        state_nxt  = S_ROW_CMB;
      end
      S_ROW_CMB: begin
        cmd.cap_hi = 1'b1;
        if (sts.last_row) begin
          state_nxt = S_FINISH;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = S_ROW_LO;
        end
      end
      S_FINISH: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

FILE: sv/wpcm_dp.sv
// datapath: map store, config registers, window lanes, nearest distance, result
module wpcm_dp #(
  parameter int MAP_SIDE   = wpcm_pkg::MAP_SIDE_DEF,
  parameter int MAX_RADIUS = wpcm_pkg::MAX_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wpcm_pkg::cmd_t              cmd,
  output wpcm_pkg::sts_t              sts,
  input  logic [9:0]                  in_tile_x,
  input  logic [9:0]                  in_tile_y,
  input  logic [wpcm_pkg::DATA_W-1:0] in_row_bits,
  input  logic                        cfg_valid,
  input  logic [0:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  output logic [15:0]                 out_weight,
  output logic                        out_is_solid,
  output logic                        out_near_wall,
  output logic [7:0]                  out_nearest_dist_sq
);
  import wpcm_pkg::*;

  localparam int ROW_WORDS = (MAP_SIDE + 63) / 64;
  localparam int DEPTH     = MAP_SIDE * ROW_WORDS;
  localparam int AW        = $clog2(DEPTH);
  localparam int NL        = 2 * MAX_RADIUS;

  // config
  logic [3:0]  radius_r;
  logic [15:0] default_r;
  logic [RAD_W-1:0] r_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= 4'd8;
      default_r <= 16'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NEAR_RADIUS:    radius_r  <= cfg_data[3:0];
        CFG_DEFAULT_WEIGHT: default_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign r_eff = (int'(radius_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_r);

  // query registers
  logic [9:0] tx_r, ty_r;
  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      tx_r <= in_tile_x;
      ty_r <= in_tile_y;
    end
  end

  // clearing sweep
  logic [AW-1:0] clr_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
  end

  // write port
  logic          wr_ok, ram_we;
  logic [AW-1:0] wr_addr, ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign wr_ok     = (int'(in_tile_y) < MAP_SIDE) && (int'(in_tile_x[9:6]) < ROW_WORDS);
  assign wr_addr   = AW'(int'(in_tile_y) * ROW_WORDS + int'(in_tile_x[9:6]));
  assign ram_we    = cmd.clr_step || (cmd.wr_in && wr_ok);
  assign ram_waddr = cmd.clr_step ? clr_addr_r : wr_addr;
  assign ram_wdata = cmd.clr_step ? '0 : in_row_bits;

  // read address generation
  logic signed [COORD_W-1:0] tx_s, row_y, x_lo, x_hi;
  logic signed [RAD_W+1:0]   oy;
  logic [WORD_W-1:0]         w_lo, w_hi, rd_w;
  logic                      row_ok, self_ok, rd_ok;
  logic [AW-1:0]             self_addr;

  assign tx_s = COORD_W'(signed'({1'b0, tx_r}));
  assign oy   = $signed({2'b0, cmd.row_idx}) - $signed({2'b0, r_eff});
  assign row_y  = COORD_W'(signed'({1'b0, ty_r})) + COORD_W'(oy);
  assign row_ok = !row_y[COORD_W-1] && (int'(row_y) < MAP_SIDE);
  assign x_lo   = tx_s - COORD_W'(signed'({1'b0, r_eff}));
  assign x_hi   = tx_s + COORD_W'(signed'({1'b0, r_eff})) - COORD_W'(1);

  always_comb begin
    w_lo = x_lo[COORD_W-1] ? '0 : x_lo[COORD_W-1:6];
    w_hi = x_hi[COORD_W-1:6];
    if (int'(w_hi) > ROW_WORDS - 1) w_hi = WORD_W'(ROW_WORDS - 1);
    if (int'(w_lo) > ROW_WORDS - 1) w_lo = WORD_W'(ROW_WORDS - 1);
  end

  assign self_ok   = (int'(tx_r) < MAP_SIDE) && (int'(ty_r) < MAP_SIDE);
  assign self_addr = AW'(int'(ty_r) * ROW_WORDS + int'(tx_r[9:6]));

  always_comb begin
    rd_w = cmd.rd_hi ? w_hi : w_lo;
    if (cmd.rd_self) ram_raddr = self_addr;
    else ram_raddr = AW'(int'(row_y) * ROW_WORDS + int'(rd_w));
  end

  always_ff @(posedge clk) begin
    rd_ok <= (cmd.rd_self && self_ok) || ((cmd.rd_lo || cmd.rd_hi) && row_ok);
  end

  logic [WORD_W-1:0] rd_w_r;
  logic              rd_ok_r;
  assign rd_ok_r = rd_ok;
  always_ff @(posedge clk) rd_w_r <= rd_w;

  wpcm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // window lanes of the word just read
  logic [NL-1:0]             lanes;
  logic signed [COORD_W-1:0] lx;
  always_comb begin
    lanes = '0;
    lx    = '0;
    for (int i = 0; i < NL; i++) begin
      lx = tx_s + COORD_W'(i - MAX_RADIUS);
      if (rd_ok_r && !lx[COORD_W-1] && (int'(lx) < MAP_SIDE) &&
          (lx[COORD_W-1:6] == rd_w_r) &&
          (i >= MAX_RADIUS - int'(r_eff)) && (i < MAX_RADIUS + int'(r_eff)))
        lanes[i] = ram_rdata[lx[5:0]];
    end
  end

  logic [NL-1:0]     lo_mask_r, row_mask_r;
  logic [RAD_W-1:0]  oy_abs_r;
  logic              eval_v_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) lo_mask_r <= lanes;
    if (cmd.cap_hi) begin
      row_mask_r <= lo_mask_r | lanes;
      oy_abs_r   <= oy[RAD_W+1] ? RAD_W'(-oy) : RAD_W'(oy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) eval_v_r <= 1'b0;
    else eval_v_r <= cmd.cap_hi;
  end

  // nearest column of the row, then squared distance
  logic [NL:0]        mp;
  logic [RAD_W-1:0]   kmin;
  logic [BEST_W-1:0]  d_row;
  always_comb begin
    mp   = {1'b0, row_mask_r};
    kmin = '0;
    for (int k = MAX_RADIUS; k >= 0; k--) begin
      if (mp[MAX_RADIUS + k] || mp[MAX_RADIUS - k]) kmin = RAD_W'(k);
    end
    d_row = BEST_W'(kmin * kmin) + BEST_W'(oy_abs_r * oy_abs_r);
  end

  logic [BEST_W-1:0] best_r;
  logic              found_r, solid_r, self_solid;

  assign self_solid = rd_ok_r && ram_rdata[tx_r[5:0]];

  always_ff @(posedge clk) begin
    if (cmd.chk_self) begin
      solid_r <= self_solid;
      found_r <= 1'b0;
      best_r  <= '1;
    end else if (eval_v_r && (|row_mask_r)) begin
      found_r <= 1'b1;
      if (d_row < best_r) best_r <= d_row;
    end
  end

  // result
  logic [BEST_W-1:0] rr;
  logic              near;
  assign rr   = BEST_W'(r_eff * r_eff);
  assign near = found_r && (best_r < rr);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (solid_r) begin
        out_weight          <= default_r;
        out_is_solid        <= 1'b1;
        out_near_wall       <= 1'b0;
        out_nearest_dist_sq <= 8'd0;
      end else begin
        out_weight          <= near ? WEIGHT_LUT[best_r[7:0]] : default_r;
        out_is_solid        <= 1'b0;
        out_near_wall       <= near;
        out_nearest_dist_sq <= !found_r ? 8'd255 :
                               (best_r > BEST_W'(254)) ? 8'd254 : best_r[7:0];
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.clr_last   = (int'(clr_addr_r) == DEPTH - 1);
    sts.self_solid = self_solid;
    sts.r_zero     = (r_eff == '0);
    sts.last_row   = ({1'b0, cmd.row_idx} == ({r_eff, 1'b0} - (RAD_W+1)'(1)));
  end
endmodule

FILE: sv/wall_proximity_cost_map.sv
// top level of the wall proximity cost map
// flow: a map write beat gives no result; a query first reads and checks its own tile; on a
//   solid tile or a radius of zero it goes straight to the result, else it reads each window
//   row, each with two reads of the single read port of the map ram and a combine
// input: a beat is taken only in idle, after the last query has loaded its result; the next
//   beat is taken while a result waits on out_ready
// reset: rst_n is synchronous; after it the map ram is swept to free, one word a cycle,
//   MAP_SIDE * ceil(MAP_SIDE/64) words (16384 by default) with in_ready low
module wall_proximity_cost_map #(
  parameter int MAP_SIDE   = wpcm_pkg::MAP_SIDE_DEF,
  parameter int MAX_RADIUS = wpcm_pkg::MAX_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel: one beat is a map write or a tile query
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [9:0]                  in_tile_x,
  input  logic [9:0]                  in_tile_y,
  input  logic [wpcm_pkg::DATA_W-1:0] in_row_bits,
  // result channel: one beat per query
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_weight,
  output logic                        out_is_solid,
  output logic                        out_near_wall,
  output logic [7:0]                  out_nearest_dist_sq,
  // config write channel, always ready
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);
  import wpcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config registers are plain flops, a write beat lands every cycle
  assign cfg_ready = 1'b1;

  // sequencer: owns the state, window row count and output valid
  wpcm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  // datapath: map ram, lane extraction, distance search and result register
  wpcm_dp #(.MAP_SIDE(MAP_SIDE), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_tile_x           (in_tile_x),
    .in_tile_y           (in_tile_y),
    .in_row_bits         (in_row_bits),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_weight          (out_weight),
    .out_is_solid        (out_is_solid),
    .out_near_wall       (out_near_wall),
    .out_nearest_dist_sq (out_nearest_dist_sq)
  );
endmodule

FILE: sv/wpcm_checker.sv
// port level checks for the wall proximity cost map, bound to the top level
module wpcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_weight,
  input logic        out_is_solid,
  input logic        out_near_wall,
  input logic [7:0]  out_nearest_dist_sq
);
  // map sweep follows reset, so no beat is taken right after it
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high during clearing sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_weight) &&
      $stable(out_nearest_dist_sq))
    else $error("stalled result beat changed");

  a_solid_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_solid |-> !out_near_wall && out_nearest_dist_sq == 8'd0)
    else $error("solid tile result inconsistent");

  a_near_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_near_wall |-> !out_is_solid && out_nearest_dist_sq != 8'd255)
    else $error("near wall without a found solid tile");
endmodule

bind wall_proximity_cost_map wpcm_checker u_wpcm_checker (.*);
